### hdl/radar_distance_frame_parser_macros.svh
// Assertion macros used by the radar frame parser RTL.
`ifndef RADAR_DISTANCE_FRAME_PARSER_MACROS_SVH
`define RADAR_DISTANCE_FRAME_PARSER_MACROS_SVH

// Clocked check, disabled while reset is high.
`define RDFP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RDFP_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/rdfp_pkg.sv
// Types and constants of the radar distance frame parser.
`default_nettype none

package rdfp_pkg;

   localparam logic [7:0] HDR_BYTE      = 8'h55;
   localparam logic [7:0] TYPE_A_BYTE   = 8'h0C;
   localparam logic [7:0] TYPE_B_BYTE   = 8'h0B;
   localparam logic [7:0] ALL_ONES_BYTE = 8'hFF;
   localparam logic [2:0] FRONT_FLAG_BIT = 3'd0;
   localparam logic [2:0] BACK_FLAG_BIT  = 3'd2;

   typedef enum logic [3:0] {
      PH_HUNT     = 4'd0,
      PH_TYPE_A   = 4'd1,
      PH_TYPE_B   = 4'd2,
      PH_FRONT_HI = 4'd3,
      PH_FRONT_LO = 4'd4,
      PH_BACK_HI  = 4'd5,
      PH_BACK_LO  = 4'd6,
      PH_SKIP0    = 4'd7,
      PH_SKIP1    = 4'd8,
      PH_FLAG     = 4'd9,
      PH_CSUM     = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD = 2'd0,
      ST_CSUM = 2'd1,
      ST_TYPE = 2'd2
   } status_type;

endpackage

`default_nettype wire

### hdl/radar_distance_frame_parser.sv
// Radar distance frame parser: byte-serial decoder of 11-byte distance frames.
//
// Takes one serial byte per req beat and decodes frames of the form 0x55, 0x0C, 0x0B,
// front distance (big endian), back distance, two ignored bytes, a flag byte and an 8-bit
// sum checksum. The checksum byte yields one rsp beat with status good (distances and
// warnings) or checksum mismatch; a wrong type byte yields one beat with status bad type.
// Each byte is registered on entry and decoded in the following cycle, so a byte can be
// taken every cycle; one result register holds the rsp beat, and the req side stalls only
// when that register is full, not being taken, and the registered byte must emit a result.
`default_nettype none

`include "radar_distance_frame_parser_macros.svh"

module radar_distance_frame_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rdfp_pkg::status_type     rsp_status,
   output logic [15:0]              rsp_front_distance,
   output logic [15:0]              rsp_back_distance,
   output logic                     rsp_front_warn,
   output logic                     rsp_back_warn
);

   import rdfp_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] front_acc_ff, front_acc_in;
   logic [15:0] back_acc_ff, back_acc_in;
   logic        high_ff_ff, high_ff_in;
   logic        front_ones_ff, front_ones_in;
   logic        back_ones_ff, back_ones_in;
   logic        front_flag_ff, front_flag_in;
   logic        back_flag_ff, back_flag_in;

   logic        emit;
   status_type  emit_status;
   logic        emit_payload;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [15:0] rsp_front_ff;
   logic [15:0] rsp_back_ff;
   logic        rsp_front_warn_ff;
   logic        rsp_back_warn_ff;

   logic        out_free;
   logic        advance;
   logic        is_ff;
   logic        bit0;
   logic        bit2;

   assign is_ff = (in_byte_ff == ALL_ONES_BYTE);
   assign bit0  = in_byte_ff[FRONT_FLAG_BIT];
   assign bit2  = in_byte_ff[BACK_FLAG_BIT];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (out_free || !emit);
   assign req_ready = !in_valid_ff || advance;

   // next phase
   always_comb begin
      unique case (phase_ff)
         PH_TYPE_A:   phase_in = (in_byte_ff == TYPE_A_BYTE) ? PH_TYPE_B : PH_HUNT;
         PH_TYPE_B:   phase_in = (in_byte_ff == TYPE_B_BYTE) ? PH_FRONT_HI : PH_HUNT;
         PH_FRONT_HI: phase_in = PH_FRONT_LO;
         PH_FRONT_LO: phase_in = PH_BACK_HI;
         PH_BACK_HI:  phase_in = PH_BACK_LO;
         PH_BACK_LO:  phase_in = PH_SKIP0;
         PH_SKIP0:    phase_in = PH_SKIP1;
         PH_SKIP1:    phase_in = PH_FLAG;
         PH_FLAG:     phase_in = PH_CSUM;
         PH_CSUM:     phase_in = PH_HUNT;
         default:     phase_in = (in_byte_ff == HDR_BYTE) ? PH_TYPE_A : PH_HUNT;
      endcase
   end

   // frame accumulators and result decode
   always_comb begin
      sum_in        = sum_ff + in_byte_ff;
      front_acc_in  = front_acc_ff;
      back_acc_in   = back_acc_ff;
      high_ff_in    = high_ff_ff;
      front_ones_in = front_ones_ff;
      back_ones_in  = back_ones_ff;
      front_flag_in = front_flag_ff;
      back_flag_in  = back_flag_ff;
      emit          = 1'b0;
      emit_status   = ST_GOOD;
      emit_payload  = 1'b0;
      unique case (phase_ff)
         PH_TYPE_A: begin
            if (in_byte_ff != TYPE_A_BYTE) begin
               emit        = 1'b1;
               emit_status = ST_TYPE;
            end
         end
         PH_TYPE_B: begin
            if (in_byte_ff != TYPE_B_BYTE) begin
               emit        = 1'b1;
               emit_status = ST_TYPE;
            end
         end
         PH_FRONT_HI: begin
            high_ff_in   = is_ff;
            front_acc_in = {in_byte_ff, 8'h00};
         end
         PH_FRONT_LO: begin
            front_acc_in  = {front_acc_ff[15:8], in_byte_ff};
            front_ones_in = high_ff_ff && is_ff;
            high_ff_in    = 1'b0;
         end
         PH_BACK_HI: begin
            high_ff_in  = is_ff;
            back_acc_in = {in_byte_ff, 8'h00};
         end
         PH_BACK_LO: begin
            back_acc_in  = {back_acc_ff[15:8], in_byte_ff};
            back_ones_in = high_ff_ff && is_ff;
            high_ff_in   = 1'b0;
         end
         PH_SKIP0, PH_SKIP1: begin
         end
         PH_FLAG: begin
            if (bit0 && front_ones_ff) begin
               front_flag_in = 1'b1;
            end else if (bit2 && back_ones_ff) begin
               back_flag_in = 1'b1;
            end
         end
         PH_CSUM: begin
            emit = 1'b1;
            if (in_byte_ff == sum_ff) begin
               emit_status  = ST_GOOD;
               emit_payload = 1'b1;
            end else begin
               emit_status = ST_CSUM;
            end
         end
         default: begin
            sum_in = sum_ff;
            if (in_byte_ff == HDR_BYTE) begin
               sum_in        = HDR_BYTE;
               front_acc_in  = '0;
               back_acc_in   = '0;
               high_ff_in    = 1'b0;
               front_ones_in = 1'b0;
               back_ones_in  = 1'b0;
               front_flag_in = 1'b0;
               back_flag_in  = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_HUNT;
         sum_ff        <= '0;
         front_acc_ff  <= '0;
         back_acc_ff   <= '0;
         high_ff_ff    <= 1'b0;
         front_ones_ff <= 1'b0;
         back_ones_ff  <= 1'b0;
         front_flag_ff <= 1'b0;
         back_flag_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            phase_ff      <= phase_in;
            sum_ff        <= sum_in;
            front_acc_ff  <= front_acc_in;
            back_acc_ff   <= back_acc_in;
            high_ff_ff    <= high_ff_in;
            front_ones_ff <= front_ones_in;
            back_ones_ff  <= back_ones_in;
            front_flag_ff <= front_flag_in;
            back_flag_ff  <= back_flag_in;
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         rsp_status_ff     <= emit_status;
         rsp_front_ff      <= emit_payload ? front_acc_ff : 16'h0000;
         rsp_back_ff       <= emit_payload ? back_acc_ff : 16'h0000;
         rsp_front_warn_ff <= emit_payload && front_flag_ff;
         rsp_back_warn_ff  <= emit_payload && back_flag_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_front_distance = rsp_front_ff;
   assign rsp_back_distance  = rsp_back_ff;
   assign rsp_front_warn     = rsp_front_warn_ff;
   assign rsp_back_warn      = rsp_back_warn_ff;

   `RDFP_ASSERT(a_bad_status_zero,
      rsp_valid_ff && (rsp_status_ff != ST_GOOD) |->
         (rsp_front_ff == 16'h0000) && (rsp_back_ff == 16'h0000) &&
         !rsp_front_warn_ff && !rsp_back_warn_ff,
      "non-good status carries payload")
   `RDFP_ASSERT(a_single_warn,
      !(front_flag_ff && back_flag_ff),
      "both warnings raised in one frame")
   `RDFP_ASSERT(a_csum_returns_hunt,
      advance && (phase_ff == PH_CSUM) |=> (phase_ff == PH_HUNT),
      "parser did not return to hunting after checksum byte")
   `RDFP_ASSERT(a_stall_only_on_full_output,
      in_valid_ff && !advance |-> rsp_valid_ff && !rsp_ready && emit,
      "byte held without a full result register")
   `RDFP_ASSERT_ALWAYS(a_reset_clears_valid,
      reset |=> !rsp_valid_ff && !in_valid_ff && (phase_ff == PH_HUNT),
      "reset left control state set")

endmodule

`default_nettype wire
